// File: design/wcg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the cosine table function for the window generator.
// Used by window_coefficient_generator and wcg_divider; depends on nothing else.
package wcg_pkg;

    localparam int MAX_LEN_DEF         = 65536;
    localparam int COS_TABLE_DEPTH_DEF = 1024;

    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WINDOW_TYPE = 3'd0,
        REG_TUKEY_ALPHA = 3'd1,
        REG_PRE_BINS    = 3'd2,
        REG_SIGNAL_LEN  = 3'd3,
        REG_TOTAL_LEN   = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        WIN_RECT  = 2'd0,
        WIN_TUKEY = 2'd1,
        WIN_HANN  = 2'd2
    } win_type_t;

    typedef enum logic [1:0] {
        COEF_ZERO = 2'd0,
        COEF_ONE  = 2'd1,
        COEF_COS  = 2'd2
    } coef_kind_t;

    // Sideband that travels with an item through the pipeline.
    typedef struct packed {
        coef_kind_t kind;
        logic       in_win;
    } wcg_side_t;

    // Cosine of angle x (Q30 radians) in Q16, by a thirteen-term Taylor series.
    // Evaluated only at elaboration to build the quarter-wave table.
    function automatic logic [16:0] quarter_cos(input logic [63:0] x);
        logic [63:0]        t;
        logic signed [65:0] sum;
        logic [63:0]        v;
        t   = 64'd1 << 30;
        sum = 66'sd1 <<< 30;
        for (int n = 1; n <= 12; n++)
        begin
            t = (((t * x) >> 30) * x) >> 30;
            t = t / 64'((2 * n - 1) * (2 * n));
            if ((n % 2) == 1)
                sum = sum - $signed({2'b00, t});
            else
                sum = sum + $signed({2'b00, t});
        end
        if (sum <= 0)
            return 17'd0;
        v = (sum[63:0] + 64'd8192) >> 14;
        if (v > 64'(ONE_Q16))
            return ONE_Q16;
        return v[16:0];
    endfunction

endpackage

// File: design/wcg_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on wcg_pkg for the sideband struct.
module wcg_divider #(
    parameter int QW = 13,
    parameter int RW = 49,
    parameter int YW = 35
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [RW-1:0]     in_num,
    input  logic [YW-1:0]     in_den,
    input  wcg_pkg::wcg_side_t in_side,
    output logic              out_valid,
    output logic [QW-1:0]     out_quot,
    output wcg_pkg::wcg_side_t out_side
);

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic               valid_reg;
        logic [RW-1:0]      rem_reg;
        logic [YW-1:0]      den_reg;
        logic [QW-1:0]      quot_reg;
        wcg_pkg::wcg_side_t side_reg;
        logic               v_in;
        logic [RW-1:0]      r_in;
        logic [YW-1:0]      d_in;
        logic [QW-1:0]      q_in;
        wcg_pkg::wcg_side_t sd_in;
        logic [RW-1:0]      shifted;
        logic               take;

        if (s == 0)
        begin : g_first
            assign v_in  = in_valid;
            assign r_in  = in_num;
            assign d_in  = in_den;
            assign q_in  = '0;
            assign sd_in = in_side;
        end
        else
        begin : g_rest
            assign v_in  = g_stage[s-1].valid_reg;
            assign r_in  = g_stage[s-1].rem_reg;
            assign d_in  = g_stage[s-1].den_reg;
            assign q_in  = g_stage[s-1].quot_reg;
            assign sd_in = g_stage[s-1].side_reg;
        end

        assign shifted = RW'(d_in) << (QW - 1 - s);
        assign take    = (r_in >= shifted);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else
                valid_reg <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg  <= take ? (r_in - shifted) : r_in;
            den_reg  <= d_in;
            side_reg <= sd_in;
            quot_reg <= q_in | (take ? (QW'(1) << (QW - 1 - s)) : '0);
        end
    end

    assign out_valid = g_stage[QW-1].valid_reg;
    assign out_quot  = g_stage[QW-1].quot_reg;
    assign out_side  = g_stage[QW-1].side_reg;

    // A finished division of a cosine item leaves a remainder below the divisor.
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_side.kind == wcg_pkg::COEF_COS)
            |-> (g_stage[QW-1].rem_reg < RW'(g_stage[QW-1].den_reg)))
        else $error("divider remainder not below divisor");

endmodule

// File: design/window_coefficient_generator.sv
`timescale 1ns / 1ps
// Top level of the window coefficient generator: configuration, classification,
// cosine phase and table lookup. Depends on wcg_pkg and wcg_divider.
//
//  Channel   Signals                               Transfer
//  input     start, busy, sample_index             start high and busy low at a clock edge
//  result    done, coefficient, in_window          done high for one cycle, always taken
//  config    cfg_write, cfg_index, cfg_data        cfg_write high at a clock edge
//
// One item is accepted every cycle; busy is never raised.
// Items pass through the input register, the classification register, the divider
// that produces one phase bit per stage, then the phase, table read and output
// registers. Reset clears all valid bits and loads the register defaults. The
// receiver cannot stall, so nothing in the pipeline ever waits.
module window_coefficient_generator #(
    parameter int MAX_LEN         = wcg_pkg::MAX_LEN_DEF,
    parameter int COS_TABLE_DEPTH = wcg_pkg::COS_TABLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [15:0]                    sample_index,
    input  logic                           cfg_write,
    input  logic [wcg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wcg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                           done,
    output logic [16:0]                    coefficient,
    output logic                           in_window
);

    localparam int PW = $clog2(4 * COS_TABLE_DEPTH + 1);
    localparam int AW = $clog2(COS_TABLE_DEPTH + 1);
    localparam int YW = 35;
    localparam int RW = YW + 1 + PW;

    // Configuration registers
    logic [1:0]  window_type_reg;
    logic [16:0] tukey_alpha_reg;
    logic [15:0] pre_bins_reg;
    logic [16:0] signal_len_reg;
    logic [16:0] total_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_type_reg <= wcg_pkg::WIN_RECT;
            tukey_alpha_reg <= 17'd32768;
            pre_bins_reg    <= 16'd0;
            signal_len_reg  <= 17'd1024;
            total_len_reg   <= 17'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                wcg_pkg::REG_WINDOW_TYPE: window_type_reg <= cfg_data[1:0];
                wcg_pkg::REG_TUKEY_ALPHA: tukey_alpha_reg <= cfg_data;
                wcg_pkg::REG_PRE_BINS:    pre_bins_reg    <= cfg_data[15:0];
                wcg_pkg::REG_SIGNAL_LEN:  signal_len_reg  <= cfg_data;
                wcg_pkg::REG_TOTAL_LEN:   total_len_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [16:0] n_sat;
    logic [16:0] tot_sat;
    logic [16:0] a_sat;
    logic [33:0] den_reg;

    assign n_sat   = (32'(signal_len_reg) > 32'(MAX_LEN)) ? 17'(MAX_LEN) : signal_len_reg;
    assign tot_sat = (32'(total_len_reg) > 32'(MAX_LEN)) ? 17'(MAX_LEN) : total_len_reg;
    assign a_sat   = (tukey_alpha_reg > wcg_pkg::ONE_Q16) ? wcg_pkg::ONE_Q16 : tukey_alpha_reg;

    // Taper denominator alpha*N is registered and follows the configuration in the next cycle.
    always_ff @(posedge clk)
    begin
        den_reg <= a_sat * n_sat;
    end

    assign busy = 1'b0;

    // Stage 1: input register
    logic        s1_valid_reg;
    logic [15:0] s1_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_index_reg <= sample_index;
    end

    // Stage 2: region decision and divider operands
    logic               in_span;
    logic [15:0]        j;
    logic [16:0]        lo;
    logic [17:0]        hi;
    logic [32:0]        num;
    logic [33:0]        dsel;
    wcg_pkg::wcg_side_t side_next;

    assign in_span = ({2'b00, s1_index_reg} >= {2'b00, pre_bins_reg})
                  && ({2'b00, s1_index_reg} < ({2'b00, pre_bins_reg} + {1'b0, n_sat}))
                  && ({1'b0, s1_index_reg} < tot_sat);
    assign j  = s1_index_reg - pre_bins_reg;
    assign lo = den_reg[33:17];
    assign hi = 18'((35'(den_reg) + 35'h1FFFF) >> 17);

    always_comb
    begin
        side_next.in_win = in_span;
        side_next.kind   = wcg_pkg::COEF_ZERO;
        num              = '0;
        dsel             = 34'd1;
        if (in_span)
        begin
            case (window_type_reg)
                wcg_pkg::WIN_RECT:
                    side_next.kind = wcg_pkg::COEF_ONE;
                wcg_pkg::WIN_HANN:
                begin
                    side_next.kind = wcg_pkg::COEF_COS;
                    num            = 33'(j);
                    dsel           = 34'(n_sat);
                end
                wcg_pkg::WIN_TUKEY:
                begin
                    if ((17'(j) < lo) && (den_reg != '0))
                    begin
                        side_next.kind = wcg_pkg::COEF_COS;
                        num            = {1'b0, j, 16'd0};
                        dsel           = den_reg;
                    end
                    else if ((18'(j) + hi) <= 18'(n_sat))
                        side_next.kind = wcg_pkg::COEF_ONE;
                    else if (den_reg != '0)
                    begin
                        side_next.kind = wcg_pkg::COEF_COS;
                        num            = {(n_sat - 17'(j)), 16'd0};
                        dsel           = den_reg;
                    end
                    else
                        side_next.kind = wcg_pkg::COEF_ONE;
                end
                default:
                    side_next.kind = wcg_pkg::COEF_ZERO;
            endcase
        end
    end

    logic               s2_valid_reg;
    logic [RW-1:0]      s2_x_reg;
    logic [YW-1:0]      s2_y_reg;
    wcg_pkg::wcg_side_t s2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    // Phase rounds half up: (num*8D + den) / (2*den).
    always_ff @(posedge clk)
    begin
        s2_x_reg    <= RW'(num) * RW'(8 * COS_TABLE_DEPTH) + RW'(dsel);
        s2_y_reg    <= {dsel, 1'b0};
        s2_side_reg <= side_next;
    end

    logic               div_valid;
    logic [PW-1:0]      div_quot;
    wcg_pkg::wcg_side_t div_side;

    wcg_divider #(
        .QW(PW),
        .RW(RW),
        .YW(YW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s2_valid_reg),
        .in_num   (s2_x_reg),
        .in_den   (s2_y_reg),
        .in_side  (s2_side_reg),
        .out_valid(div_valid),
        .out_quot (div_quot),
        .out_side (div_side)
    );

    // Phase to quadrant and table address
    localparam logic [PW-1:0] D1 = PW'(COS_TABLE_DEPTH);
    localparam logic [PW-1:0] D2 = PW'(2 * COS_TABLE_DEPTH);
    localparam logic [PW-1:0] D3 = PW'(3 * COS_TABLE_DEPTH);
    localparam logic [PW-1:0] D4 = PW'(4 * COS_TABLE_DEPTH);

    logic [PW-1:0] pm;
    logic [PW-1:0] r;
    logic [PW-1:0] addr_full;
    logic          neg;

    always_comb
    begin
        pm = (div_quot == D4) ? '0 : div_quot;
        if (pm < D1)
        begin
            r         = pm;
            addr_full = r;
            neg       = 1'b0;
        end
        else if (pm < D2)
        begin
            r         = pm - D1;
            addr_full = D1 - r;
            neg       = 1'b1;
        end
        else if (pm < D3)
        begin
            r         = pm - D2;
            addr_full = r;
            neg       = 1'b1;
        end
        else
        begin
            r         = pm - D3;
            addr_full = D1 - r;
            neg       = 1'b0;
        end
    end

    logic               ph_valid_reg;
    logic [AW-1:0]      ph_addr_reg;
    logic               ph_neg_reg;
    wcg_pkg::wcg_side_t ph_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ph_valid_reg <= 1'b0;
        else
            ph_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        ph_addr_reg <= AW'(addr_full);
        ph_neg_reg  <= neg;
        ph_side_reg <= div_side;
    end

    // Quarter-wave cosine table, read through a register
    logic [16:0] cos_rom [COS_TABLE_DEPTH + 1];

    for (genvar g = 0; g <= COS_TABLE_DEPTH; g++)
    begin : g_rom
        assign cos_rom[g] = wcg_pkg::quarter_cos(
            (64'(g) * wcg_pkg::HALF_PI_Q30) / 64'(COS_TABLE_DEPTH));
    end

    logic               rd_valid_reg;
    logic [16:0]        rd_cos_reg;
    logic               rd_neg_reg;
    wcg_pkg::wcg_side_t rd_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else
            rd_valid_reg <= ph_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        rd_cos_reg  <= cos_rom[ph_addr_reg];
        rd_neg_reg  <= ph_neg_reg;
        rd_side_reg <= ph_side_reg;
    end

    // Output: (1 - cos) / 2 with the half rounded up
    logic signed [18:0] cos_s;
    logic signed [18:0] raised;
    logic [16:0]        coef_next;

    assign cos_s  = rd_neg_reg ? -$signed({2'b00, rd_cos_reg}) : $signed({2'b00, rd_cos_reg});
    assign raised = (19'sd65537 - cos_s) >>> 1;

    always_comb
    begin
        case (rd_side_reg.kind)
            wcg_pkg::COEF_ONE: coef_next = wcg_pkg::ONE_Q16;
            wcg_pkg::COEF_COS: coef_next = raised[16:0];
            default:           coef_next = 17'd0;
        endcase
    end

    logic        done_reg;
    logic [16:0] coefficient_reg;
    logic        in_window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= rd_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        coefficient_reg <= coef_next;
        in_window_reg   <= rd_side_reg.in_win;
    end

    assign done        = done_reg;
    assign coefficient = coefficient_reg;
    assign in_window   = in_window_reg;

    a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (coefficient <= wcg_pkg::ONE_Q16))
        else $error("coefficient above one");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_window) |-> (coefficient == 17'd0))
        else $error("nonzero coefficient outside the window");

    a_rect_one: assert property (@(posedge clk) disable iff (!rst_n)
        (done && in_window && window_type_reg == wcg_pkg::WIN_RECT)
            |-> (coefficient == wcg_pkg::ONE_Q16))
        else $error("rectangular window not one inside");

endmodule
